@@ sv/kaf_pkg.sv @@
// shared types and constants for the kalman angle filter
package kaf_pkg;

    localparam int unsigned CfgAddrW = 4;

    localparam logic [1:0] RegAngleNoise = 2'd0;
    localparam logic [1:0] RegBiasNoise  = 2'd1;
    localparam logic [1:0] RegMeasNoise  = 2'd2;
    localparam logic [1:0] RegStartAngle = 2'd3;

    // multiplier operand selects
    typedef enum logic [3:0] {
        t_MUL_DT_RATE,
        t_MUL_DT_C11,
        t_MUL_DT_T,
        t_MUL_BPN_DT,
        t_MUL_K0_Y,
        t_MUL_K1_Y,
        t_MUL_K0_P00,
        t_MUL_K0_P01,
        t_MUL_K1_P00,
        t_MUL_K1_P01
    } t_mul_sel;

    typedef enum logic [3:0] {
        t_OP_NONE,
        t_OP_START,
        t_OP_MUL,
        t_OP_PRED,
        t_OP_DIV0_START,
        t_OP_DIV1_START,
        t_OP_DIV_STEP,
        t_OP_DIV0_END,
        t_OP_DIV1_END,
        t_OP_INNOV
    } t_op;

    typedef struct packed {
        t_op      op;
        t_mul_sel sel;
        logic     save;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic s_pos;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

@@ sv/kaf_datapath.sv @@
// kalman filter datapath: state, shared multiplier and restoring divider
module kaf_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kaf_pkg::t_cmd        i_cmd,
    output kaf_pkg::t_status     o_status,
    input  logic signed [24:0]   i_meas,
    input  logic signed [24:0]   i_gyro,
    input  logic [16:0]          i_dt,
    input  logic [15:0]          i_apn,
    input  logic [15:0]          i_bpn,
    input  logic [19:0]          i_mn,
    input  logic signed [24:0]   i_start,
    input  logic                 i_load_start,
    output logic signed [31:0]   o_angle,
    output logic signed [31:0]   o_rate,
    output logic signed [31:0]   o_bias
);
    localparam int DivW = 32 + FRAC_BITS;
    localparam int CntW = $clog2(DivW + 1);

    logic signed [31:0] r_angle, r_bias, r_c00, r_c01, r_c10, r_c11;
    logic signed [31:0] r_rate, r_t, r_d, r_k0, r_k1, r_y, r_p00, r_p01;
    logic signed [31:0] r_prod;
    logic [3:0]         r_mstep;
    logic signed [31:0] r_ma, r_mb;
    logic signed [63:0] r_mp;

    logic [DivW-1:0]    r_quo;
    logic [33:0]        r_rem;
    logic [32:0]        r_den;
    logic               r_neg;
    logic [CntW-1:0]    r_cnt;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] rnd;
    logic signed [31:0] prod_sat;
    logic signed [33:0] s_val;
    logic [33:0]        rem_sh;
    logic [33:0]        rem_sub;
    logic signed [DivW:0] q_signed;
    logic signed [31:0] q_sat;
    logic [31:0]        num_abs;
    logic signed [31:0] num_src;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.sel)
            kaf_pkg::t_MUL_DT_RATE: begin mul_a = 32'(signed'({15'd0, i_dt})); mul_b = r_rate; end
            kaf_pkg::t_MUL_DT_C11:  begin mul_a = 32'(signed'({15'd0, i_dt})); mul_b = r_c11; end
            kaf_pkg::t_MUL_DT_T:    begin mul_a = 32'(signed'({15'd0, i_dt})); mul_b = r_t; end
            kaf_pkg::t_MUL_BPN_DT:  begin mul_a = 32'(signed'({16'd0, i_bpn}));
                                          mul_b = 32'(signed'({15'd0, i_dt})); end
            kaf_pkg::t_MUL_K0_Y:    begin mul_a = r_k0; mul_b = r_y; end
            kaf_pkg::t_MUL_K1_Y:    begin mul_a = r_k1; mul_b = r_y; end
            kaf_pkg::t_MUL_K0_P00:  begin mul_a = r_k0; mul_b = r_p00; end
            kaf_pkg::t_MUL_K0_P01:  begin mul_a = r_k0; mul_b = r_p01; end
            kaf_pkg::t_MUL_K1_P00:  begin mul_a = r_k1; mul_b = r_p00; end
            kaf_pkg::t_MUL_K1_P01:  begin mul_a = r_k1; mul_b = r_p01; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // floor of (p + half) >> frac, done as arithmetic shift
    assign rnd      = (r_mp + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign prod_sat = kaf_pkg::sat32(66'(rnd));

    assign s_val = 34'(r_c00) + 34'(signed'({14'd0, i_mn}));
    assign num_src = (i_cmd.op == kaf_pkg::t_OP_DIV1_START) ? r_c10 : r_c00;
    assign num_abs = num_src[31] ? 32'(-num_src) : num_src;
    assign rem_sh  = {r_rem[32:0], r_quo[DivW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign q_signed = r_neg ? -(DivW+1)'(signed'({1'b0, r_quo}))
                            :  (DivW+1)'(signed'({1'b0, r_quo}));
    assign q_sat = kaf_pkg::sat32(66'(q_signed));

    assign o_status.div_done = (r_cnt == '0);
    assign o_status.s_pos    = (s_val > 34'sd0);

    always_ff @(posedge i_clk) begin
        r_mp <= r_ma * r_mb;
        if (i_cmd.op == kaf_pkg::t_OP_MUL) begin
            r_ma <= mul_a;
            r_mb <= mul_b;
        end
        if (i_cmd.save) begin
            r_prod <= prod_sat;
        end
        if (!i_rst_n) begin
            r_angle <= '0;
            r_bias  <= '0;
            r_c00   <= '0;
            r_c01   <= '0;
            r_c10   <= '0;
            r_c11   <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_load_start) begin
                r_angle <= 32'(i_start);
            end
            case (i_cmd.op)
                kaf_pkg::t_OP_START: begin
                    r_rate <= kaf_pkg::sat32(66'(i_gyro) - 66'(r_bias));
                end
                kaf_pkg::t_OP_PRED: begin
                    case (i_cmd.sel)
                        kaf_pkg::t_MUL_DT_RATE:
                            r_angle <= kaf_pkg::sat32(66'(r_angle) + 66'(r_prod));
                        kaf_pkg::t_MUL_DT_C11: begin
                            r_t <= kaf_pkg::sat32(66'(r_prod) - 66'(r_c01) - 66'(r_c10)
                                                  + 66'(signed'({1'b0, i_apn})));
                            r_d <= r_prod;
                        end
                        kaf_pkg::t_MUL_DT_T: begin
                            r_c00 <= kaf_pkg::sat32(66'(r_c00) + 66'(r_prod));
                            r_c01 <= kaf_pkg::sat32(66'(r_c01) - 66'(r_d));
                            r_c10 <= kaf_pkg::sat32(66'(r_c10) - 66'(r_d));
                        end
                        kaf_pkg::t_MUL_BPN_DT:
                            r_c11 <= kaf_pkg::sat32(66'(r_c11) + 66'(r_prod));
                        kaf_pkg::t_MUL_K0_Y:
                            r_angle <= kaf_pkg::sat32(66'(r_angle) + 66'(r_prod));
                        kaf_pkg::t_MUL_K1_Y:
                            r_bias <= kaf_pkg::sat32(66'(r_bias) + 66'(r_prod));
                        kaf_pkg::t_MUL_K0_P00:
                            r_c00 <= kaf_pkg::sat32(66'(r_c00) - 66'(r_prod));
                        kaf_pkg::t_MUL_K0_P01:
                            r_c01 <= kaf_pkg::sat32(66'(r_c01) - 66'(r_prod));
                        kaf_pkg::t_MUL_K1_P00:
                            r_c10 <= kaf_pkg::sat32(66'(r_c10) - 66'(r_prod));
                        kaf_pkg::t_MUL_K1_P01:
                            r_c11 <= kaf_pkg::sat32(66'(r_c11) - 66'(r_prod));
                        default: ;
                    endcase
                end
                kaf_pkg::t_OP_DIV0_START, kaf_pkg::t_OP_DIV1_START: begin
                    r_quo <= DivW'({num_abs, FRAC_BITS'(0)});
                    r_rem <= '0;
                    r_den <= s_val[32:0];
                    r_neg <= num_src[31];
                    r_cnt <= CntW'(DivW);
                end
                kaf_pkg::t_OP_DIV_STEP: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - 1'b1;
                        if (!rem_sub[33]) begin
                            r_rem <= rem_sub;
                            r_quo <= {r_quo[DivW-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_quo <= {r_quo[DivW-2:0], 1'b0};
                        end
                    end
                end
                kaf_pkg::t_OP_DIV0_END: begin
                    r_k0 <= o_status.s_pos ? q_sat : '0;
                end
                kaf_pkg::t_OP_DIV1_END: begin
                    r_k1 <= o_status.s_pos ? q_sat : '0;
                end
                kaf_pkg::t_OP_INNOV: begin
                    r_y   <= kaf_pkg::sat32(66'(i_meas) - 66'(r_angle));
                    r_p00 <= r_c00;
                    r_p01 <= r_c01;
                end
                default: ;
            endcase
        end
    end

    assign o_angle = r_angle;
    assign o_rate  = r_rate;
    assign o_bias  = r_bias;
endmodule

@@ sv/kaf_ctrl.sv @@
// kalman filter sequencer: handshakes and step ordering
module kaf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_in_stall,
    output logic             o_valid,
    input  logic             i_out_stall,
    output logic             o_capture,
    output kaf_pkg::t_cmd    o_cmd,
    input  kaf_pkg::t_status i_status
);
    typedef enum logic [3:0] {
        S_IDLE, S_RATE, S_MLOAD, S_MWAIT, S_MSAVE, S_MAPPLY,
        S_D0, S_D0RUN, S_D0END, S_D1, S_D1RUN, S_D1END, S_INNOV, S_OUT
    } t_state;

    t_state           r_state;
    logic [3:0]       r_idx;
    logic             r_valid;
    kaf_pkg::t_mul_sel cur_sel;

    assign cur_sel = kaf_pkg::t_mul_sel'(r_idx);
    assign o_in_stall = (r_state != S_IDLE) || r_valid;
    assign o_capture  = i_valid && !o_in_stall;
    assign o_valid    = r_valid;

    always_comb begin
        o_cmd.op   = kaf_pkg::t_OP_NONE;
        o_cmd.sel  = cur_sel;
        o_cmd.save = 1'b0;
        case (r_state)
            S_RATE:  o_cmd.op = kaf_pkg::t_OP_START;
            S_MLOAD: o_cmd.op = kaf_pkg::t_OP_MUL;
            S_MSAVE: o_cmd.save = 1'b1;
            S_MAPPLY: o_cmd.op = kaf_pkg::t_OP_PRED;
            S_D0:    o_cmd.op = kaf_pkg::t_OP_DIV0_START;
            S_D1:    o_cmd.op = kaf_pkg::t_OP_DIV1_START;
            S_D0RUN, S_D1RUN: o_cmd.op = kaf_pkg::t_OP_DIV_STEP;
            S_D0END: o_cmd.op = kaf_pkg::t_OP_DIV0_END;
            S_D1END: o_cmd.op = kaf_pkg::t_OP_DIV1_END;
            S_INNOV: o_cmd.op = kaf_pkg::t_OP_INNOV;
            default: o_cmd.op = kaf_pkg::t_OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_out_stall) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (o_capture) begin
                    r_state <= S_RATE;
                end
                S_RATE: begin
                    r_idx   <= 4'(kaf_pkg::t_MUL_DT_RATE);
                    r_state <= S_MLOAD;
                end
                S_MLOAD: r_state <= S_MWAIT;
                S_MWAIT: r_state <= S_MSAVE;
                S_MSAVE: r_state <= S_MAPPLY;
                S_MAPPLY: begin
                    r_idx <= r_idx + 1'b1;
                    if (cur_sel == kaf_pkg::t_MUL_BPN_DT) begin
                        r_state <= S_D0;
                    end else if (cur_sel == kaf_pkg::t_MUL_K1_P01) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MLOAD;
                    end
                end
                S_D0:    r_state <= S_D0RUN;
                S_D0RUN: if (i_status.div_done) r_state <= S_D0END;
                S_D0END: r_state <= S_D1;
                S_D1:    r_state <= S_D1RUN;
                S_D1RUN: if (i_status.div_done) r_state <= S_D1END;
                S_D1END: r_state <= S_INNOV;
                S_INNOV: r_state <= S_MLOAD;
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ sv/kalman_angle_filter.sv @@
// kalman angle filter top level: apb registers, input capture, result register
// Two-state Kalman filter (angle, gyro bias) in Q format with FRAC_BITS fraction
// bits. One request at a time: ten multiplies through one shared multiplier
// (each through load, wait, save and apply states) and two restoring divisions
// of 32+FRAC_BITS steps each (plus start and end states) lie on the way from
// acceptance to result. The result register holds until taken; a new request is
// accepted the cycle after the previous result has left. Writing start_angle
// reloads the angle estimate.
module kalman_angle_filter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [kaf_pkg::CfgAddrW-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [24:0]  i_measured_angle,
    input  logic signed [24:0]  i_gyro_rate,
    input  logic [16:0]         i_time_step,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_filtered_angle,
    output logic signed [31:0]  o_corrected_rate,
    output logic signed [31:0]  o_bias_estimate
);
    logic [15:0]        r_apn, r_bpn;
    logic [19:0]        r_mn;
    logic signed [24:0] r_start;
    logic signed [24:0] r_meas, r_gyro;
    logic [16:0]        r_dt;
    logic               wr, capture, load_start;
    logic [1:0]         widx;
    kaf_pkg::t_cmd      cmd;
    kaf_pkg::t_status   status;

    assign pready = 1'b1;
    assign widx   = paddr[3:2];
    assign wr     = psel && penable && pwrite;
    assign load_start = wr && (widx == kaf_pkg::RegStartAngle);

    always_comb begin
        case (widx)
            kaf_pkg::RegAngleNoise: prdata = {16'd0, r_apn};
            kaf_pkg::RegBiasNoise:  prdata = {16'd0, r_bpn};
            kaf_pkg::RegMeasNoise:  prdata = {12'd0, r_mn};
            kaf_pkg::RegStartAngle: prdata = 32'(r_start);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apn   <= 16'd66;
            r_bpn   <= 16'd197;
            r_mn    <= 20'd1966;
            r_start <= '0;
        end else if (wr) begin
            case (widx)
                kaf_pkg::RegAngleNoise: r_apn   <= pwdata[15:0];
                kaf_pkg::RegBiasNoise:  r_bpn   <= pwdata[15:0];
                kaf_pkg::RegMeasNoise:  r_mn    <= pwdata[19:0];
                kaf_pkg::RegStartAngle: r_start <= pwdata[24:0];
                default: ;
            endcase
        end
        if (capture) begin
            r_meas <= i_measured_angle;
            r_gyro <= i_gyro_rate;
            r_dt   <= i_time_step;
        end
    end

    kaf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_in_stall (o_stall),
        .o_valid    (o_valid),
        .i_out_stall(i_stall),
        .o_capture  (capture),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    kaf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_meas      (r_meas),
        .i_gyro      (r_gyro),
        .i_dt        (r_dt),
        .i_apn       (r_apn),
        .i_bpn       (r_bpn),
        .i_mn        (r_mn),
        .i_start     (load_start ? signed'(pwdata[24:0]) : r_start),
        .i_load_start(load_start),
        .o_angle     (o_filtered_angle),
        .o_rate      (o_corrected_rate),
        .o_bias      (o_bias_estimate)
    );
endmodule

@@ verif/kaf_checker.sv @@
// checker for the kalman angle filter: predicts filter outputs and compares
module kaf_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [kaf_pkg::CfgAddrW-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic signed [24:0] i_measured_angle,
    input  logic signed [24:0] i_gyro_rate,
    input  logic [16:0]        i_time_step,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] o_filtered_angle,
    input  logic signed [31:0] o_corrected_rate,
    input  logic signed [31:0] o_bias_estimate,
    output int                 o_fail_count,
    output int                 o_pending
);
    typedef struct packed {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
        logic signed [31:0] bias;
    } t_filter_out;

    t_filter_out filter_queue[$];

    logic [15:0] angle_noise;
    logic [15:0] bias_noise;
    logic [19:0] meas_noise;
    logic signed [31:0] angle_est, gyro_bias, p00, p01, p10, p11;

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + (64'sd1 <<< 15);
        return clip32(p >>> 16);
    endfunction

    function automatic logic signed [31:0] qdiv(input logic signed [31:0] num,
                                                input longint den);
        longint n;
        n = longint'(num) * 65536;
        return clip32(n / den);
    endfunction

    task automatic filter_step(input logic signed [24:0] meas,
                               input logic signed [24:0] gyro,
                               input logic [16:0] dt_in);
        logic signed [31:0] dt, rate, t, d, k0, k1, y, q00, q01;
        longint s;
        t_filter_out res;
        dt = {15'd0, dt_in};
        rate = clip32(longint'(gyro) - longint'(gyro_bias));
        angle_est = clip32(longint'(angle_est) + longint'(qmul(dt, rate)));
        t = clip32(longint'(qmul(dt, p11)) - longint'(p01) - longint'(p10)
                   + longint'(angle_noise));
        p00 = clip32(longint'(p00) + longint'(qmul(dt, t)));
        d = qmul(dt, p11);
        p01 = clip32(longint'(p01) - longint'(d));
        p10 = clip32(longint'(p10) - longint'(d));
        p11 = clip32(longint'(p11) + longint'(qmul({16'd0, bias_noise}, dt)));
        s = longint'(p00) + longint'(meas_noise);
        if (s > 0) begin
            k0 = qdiv(p00, s);
            k1 = qdiv(p10, s);
        end else begin
            k0 = 0;
            k1 = 0;
        end
        y = clip32(longint'(meas) - longint'(angle_est));
        angle_est = clip32(longint'(angle_est) + longint'(qmul(k0, y)));
        gyro_bias = clip32(longint'(gyro_bias) + longint'(qmul(k1, y)));
        q00 = p00;
        q01 = p01;
        p00 = clip32(longint'(p00) - longint'(qmul(k0, q00)));
        p01 = clip32(longint'(p01) - longint'(qmul(k0, q01)));
        p10 = clip32(longint'(p10) - longint'(qmul(k1, q00)));
        p11 = clip32(longint'(p11) - longint'(qmul(k1, q01)));
        res.angle = angle_est;
        res.rate = rate;
        res.bias = gyro_bias;
        filter_queue.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_filter_out exp_out;
        if (!i_rst_n) begin
            angle_noise = 16'd66;
            bias_noise = 16'd197;
            meas_noise = 20'd1966;
            angle_est = 0;
            gyro_bias = 0;
            p00 = 0;
            p01 = 0;
            p10 = 0;
            p11 = 0;
            o_fail_count = 0;
            filter_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    kaf_pkg::RegAngleNoise: angle_noise = pwdata[15:0];
                    kaf_pkg::RegBiasNoise:  bias_noise = pwdata[15:0];
                    kaf_pkg::RegMeasNoise:  meas_noise = pwdata[19:0];
                    kaf_pkg::RegStartAngle: angle_est = {{7{pwdata[24]}}, pwdata[24:0]};
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                filter_step(i_measured_angle, i_gyro_rate, i_time_step);
            if (o_valid && !i_stall) begin
                if (filter_queue.size() == 0) begin
                    $error("result with no request pending");
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_out = filter_queue.pop_front();
                    if (o_filtered_angle !== exp_out.angle) begin
                        $error("filtered_angle expected %0d actual %0d",
                               exp_out.angle, o_filtered_angle);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (o_corrected_rate !== exp_out.rate) begin
                        $error("corrected_rate expected %0d actual %0d",
                               exp_out.rate, o_corrected_rate);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (o_bias_estimate !== exp_out.bias) begin
                        $error("bias_estimate expected %0d actual %0d",
                               exp_out.bias, o_bias_estimate);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = filter_queue.size();
    end
endmodule

@@ verif/tb_kalman_angle_filter.sv @@
// testbench top for the kalman angle filter: stimulus, register writes, verdict
module tb_kalman_angle_filter;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [kaf_pkg::CfgAddrW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [24:0] i_measured_angle = '0;
    logic signed [24:0] i_gyro_rate = '0;
    logic [16:0] i_time_step = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [31:0] o_filtered_angle, o_corrected_rate, o_bias_estimate;
    int fail_count, pending;
    int stall_left = 0;
    bit stall_on = 1'b1;

    always #4 i_clk = ~i_clk;

    kalman_angle_filter DUT (.*);
    kaf_checker u_checker (.*, .o_fail_count(fail_count), .o_pending(pending));

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 200);
    endfunction

    // output side stall runs of random length
    always @(posedge i_clk) begin
        if (!stall_on) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 30) begin
            i_stall <= 1'b1;
            stall_left <= gap_len();
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1;
        paddr <= kaf_pkg::CfgAddrW'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send(input logic signed [24:0] meas, input logic signed [24:0] gyro,
                        input logic [16:0] dt);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_measured_angle <= meas;
        i_gyro_rate <= gyro;
        i_time_step <= dt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic random_item(input int mode);
        logic signed [24:0] m, g;
        logic [16:0] dt;
        if (mode == 0) begin
            m = $signed(25'($urandom_range(0, 2 * 11796480))) - 25'sd11796480;
            g = $signed(25'($urandom_range(0, 2 * 16384000))) - 25'sd16384000;
            dt = $urandom_range(0, 3) == 0 ? 17'($urandom_range(0, 65536))
                                           : 17'($urandom_range(0, 1000));
        end else begin
            m = 25'($urandom);
            g = 25'($urandom);
            dt = 17'($urandom);
        end
        send(m, g, dt);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed
        send(25'sd11796480, 25'sd16384000, 17'd65536);
        send(-25'sd11796480, -25'sd16384000, 17'd65536);
        send(25'sd0, 25'sd0, 17'd0);
        send(25'sd0, 25'sd65536, 17'd655);
        send(25'sh0ffffff, 25'sh1000000, 17'h1ffff);
        send(25'sh1000000, 25'sh0ffffff, 17'h1ffff);
        send(-25'sd1, -25'sd1, 17'd1);
        stall_on = 1'b0;
        drain();
        reg_write(kaf_pkg::RegAngleNoise, 32'd65535);
        reg_write(kaf_pkg::RegBiasNoise, 32'd65535);
        reg_write(kaf_pkg::RegMeasNoise, 32'd1);
        reg_write(kaf_pkg::RegStartAngle, 32'(-11796480));
        stall_on = 1'b1;
        repeat (8) send(25'sd11796480, 25'sd100000, 17'd65536);
        send(25'sh1000000, 25'sh1000000, 17'h1ffff);
        send(25'sh0ffffff, 25'sh0ffffff, 17'h1ffff);
        drain();
        reg_write(kaf_pkg::RegAngleNoise, 32'd0);
        reg_write(kaf_pkg::RegBiasNoise, 32'd0);
        reg_write(kaf_pkg::RegMeasNoise, 32'd655360);
        reg_write(kaf_pkg::RegStartAngle, 32'd11796480);
        repeat (5) send(-25'sd11796480, 25'sd0, 17'd65536);
        drain();
        // random phases with varied settings
        for (int ph = 0; ph < 6; ph++) begin
            reg_write(kaf_pkg::RegAngleNoise, 32'($urandom_range(0, 65535)));
            reg_write(kaf_pkg::RegBiasNoise, 32'($urandom_range(0, 65535)));
            reg_write(kaf_pkg::RegMeasNoise,
                      ph == 5 ? 32'hfffff : 32'($urandom_range(1, 655360)));
            reg_write(kaf_pkg::RegStartAngle, 32'($urandom));
            for (int n = 0; n < 310; n++) random_item($urandom_range(0, 9) == 0);
            drain();
        end
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("FAIL");
        $finish;
    end
endmodule
